// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: hw/rtl/slv_pkg.sv
// ----------------------------------------------------------------------------
// slv_pkg
// Types, constants and functions of the software load verifier.
// ----------------------------------------------------------------------------
`default_nettype none

package slv_pkg;

  localparam int unsigned CRC_W     = 32;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned VERDICT_W = 2;
  localparam int unsigned CNT_W     = 4;

  localparam logic [CNT_W-1:0] PN_LEN     = 4'd14;
  localparam logic [CNT_W-1:0] CNT_MAX    = 4'd15;
  localparam logic [CNT_W-1:0] POS_P      = 4'd0;
  localparam logic [CNT_W-1:0] POS_N      = 4'd1;
  localparam logic [CNT_W-1:0] POS_DASH_A = 4'd2;
  localparam logic [CNT_W-1:0] POS_DASH_B = 4'd10;

  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

  localparam logic [DATA_W-1:0] CH_P    = 8'h50;
  localparam logic [DATA_W-1:0] CH_N    = 8'h4E;
  localparam logic [DATA_W-1:0] CH_DASH = 8'h2D;
  localparam logic [DATA_W-1:0] CH_0    = 8'h30;
  localparam logic [DATA_W-1:0] CH_9    = 8'h39;

  typedef enum logic [CMD_W-1:0] {
    CMD_CHAR   = 2'd0,
    CMD_IMAGE  = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_e;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_OK      = 2'd0,
    VERDICT_BAD_PN  = 2'd1,
    VERDICT_EMPTY   = 2'd2,
    VERDICT_CRC_BAD = 2'd3
  } verdict_e;

  // request held in the input register
  typedef struct packed {
    logic              valid;
    logic [CMD_W-1:0]  command;
    logic [DATA_W-1:0] data;
  } item_t;

  typedef struct packed {
    verdict_e         verdict;
    logic [CRC_W-1:0] crc;
  } result_t;

  // reflected CRC-32, one byte
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] rem,
                                                input logic [DATA_W-1:0] b);
    logic [CRC_W-1:0] r;
    r = rem ^ {{(CRC_W-DATA_W){1'b0}}, b};
    for (int i = 0; i < DATA_W; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  // does character ch fit position pos of PN-ddddddd-ddd
  function automatic logic char_fits(input logic [CNT_W-1:0] pos,
                                     input logic [DATA_W-1:0] ch);
    logic is_dig;
    logic fits;
    is_dig = (ch >= CH_0) && (ch <= CH_9);
    case (pos) inside
      POS_P:                  fits = (ch == CH_P);
      POS_N:                  fits = (ch == CH_N);
      POS_DASH_A, POS_DASH_B: fits = (ch == CH_DASH);
      default:                fits = (pos < PN_LEN) ? is_dig : 1'b1;
    endcase
    return fits;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/software_load_verifier_top.sv
// A finish request passes the input register and then the result register.
// Throughput: one request per cycle while the input is not stalled; the bytewise
// CRC update is combinational XOR logic between input register and load state.
// A finish stalls the input only while the result register is full and stalled.
// Reset (rst_ni low, asynchronous): both stages empty, CRC all ones, count zero,
// format ok, no image seen, expected CRC zero.
// ----------------------------------------------------------------------------
// software_load_verifier_top
// Part-number format check and CRC-32 image check with a finish report.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module software_load_verifier_top
  import slv_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CRC_W-1:0]     cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [CMD_W-1:0]     in_command_i,
  input  wire logic [DATA_W-1:0]    in_data_byte_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [VERDICT_W-1:0]      out_verdict_o,
  output logic [CRC_W-1:0]          out_computed_crc_o
);

  item_t   item;
  logic    advance;
  logic    out_blocked;
  logic    res_valid;
  result_t res;

  slv_in_stage u_in_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_command_i   (in_command_i),
    .in_data_byte_i (in_data_byte_i),
    .advance_i      (advance),
    .in_stall_o     (in_stall_o),
    .item_o         (item)
  );

  slv_track u_track (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .item_i        (item),
    .out_blocked_i (out_blocked),
    .advance_o     (advance),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  slv_out_stage u_out_stage (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .res_valid_i        (res_valid),
    .res_i              (res),
    .out_stall_i        (out_stall_i),
    .out_blocked_o      (out_blocked),
    .out_valid_o        (out_valid_o),
    .out_verdict_o      (out_verdict_o),
    .out_computed_crc_o (out_computed_crc_o)
  );

  // input stalls only behind a finish waiting for a full result register
  `ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, in_stall_o, item.valid && (item.command == CMD_FINISH) && out_valid_o && out_stall_i, "input stall without a blocked finish")
  // a finish that leaves the input register shows up as a result
  `ASSERT_NEXT(a_finish_result, clk_i, rst_ni, res_valid, out_valid_o, "finish produced no result")
  // empty image always reports a zero CRC
  `ASSERT_IMPL(a_empty_crc, clk_i, rst_ni, out_valid_o && (out_verdict_o == VERDICT_EMPTY), out_computed_crc_o == '0, "empty image with nonzero CRC")

endmodule

`default_nettype wire

// File: hw/rtl/slv_in_stage.sv
// ----------------------------------------------------------------------------
// slv_in_stage
// Input register; holds one request until the tracker consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module slv_in_stage
  import slv_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [CMD_W-1:0]  in_command_i,
  input  wire logic [DATA_W-1:0] in_data_byte_i,
  input  wire logic              advance_i,
  output logic                   in_stall_o,
  output item_t                  item_o
);

  logic              valid_q, valid_d;
  logic [CMD_W-1:0]  cmd_q;
  logic [DATA_W-1:0] data_q;
  logic              load;

  assign in_stall_o = valid_q & ~advance_i;
  assign load       = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q  <= in_command_i;
      data_q <= in_data_byte_i;
    end
  end

  assign item_o = '{valid: valid_q, command: cmd_q, data: data_q};

endmodule

`default_nettype wire

// File: hw/rtl/slv_track.sv
// ----------------------------------------------------------------------------
// slv_track
// Load state: CRC remainder, part-number checks, expected CRC, verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module slv_track
  import slv_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CRC_W-1:0]  cfg_wdata_i,
  input  wire item_t             item_i,
  input  wire logic              out_blocked_i,
  output logic                   advance_o,
  output logic                   res_valid_o,
  output result_t                res_o
);

  logic [CRC_W-1:0] crc_q, crc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             fmt_ok_q, fmt_ok_d;
  logic             seen_q, seen_d;
  logic [CRC_W-1:0] exp_q;
  logic             is_finish;
  logic             fire;
  logic [CRC_W-1:0] crc_final;
  verdict_e         verdict;

  assign is_finish = (item_i.command == CMD_FINISH);
  // only a finish needs room in the result register
  assign advance_o = ~(item_i.valid & is_finish & out_blocked_i);
  assign fire      = item_i.valid & advance_o;

  assign crc_final = crc_q ^ CRC_INIT;

  always_comb begin
    if (!fmt_ok_q || (cnt_q != PN_LEN)) begin
      verdict = VERDICT_BAD_PN;
    end else if (!seen_q) begin
      verdict = VERDICT_EMPTY;
    end else if (crc_final != exp_q) begin
      verdict = VERDICT_CRC_BAD;
    end else begin
      verdict = VERDICT_OK;
    end
  end

  always_comb begin
    crc_d    = crc_q;
    cnt_d    = cnt_q;
    fmt_ok_d = fmt_ok_q;
    seen_d   = seen_q;
    if (fire) begin
      case (item_i.command)
        CMD_CHAR: begin
          if (!char_fits(cnt_q, item_i.data)) begin
            fmt_ok_d = 1'b0;
          end
          if (cnt_q != CNT_MAX) begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        CMD_IMAGE: begin
          crc_d  = crc_byte(crc_q, item_i.data);
          seen_d = 1'b1;
        end
        CMD_FINISH: begin
          crc_d    = CRC_INIT;
          cnt_d    = '0;
          fmt_ok_d = 1'b1;
          seen_d   = 1'b0;
        end
        default: ;  // unused command: no effect
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q    <= CRC_INIT;
      cnt_q    <= '0;
      fmt_ok_q <= 1'b1;
      seen_q   <= 1'b0;
      exp_q    <= '0;
    end else begin
      crc_q    <= crc_d;
      cnt_q    <= cnt_d;
      fmt_ok_q <= fmt_ok_d;
      seen_q   <= seen_d;
      if (cfg_we_i) begin
        exp_q <= cfg_wdata_i;
      end
    end
  end

  assign res_valid_o = fire & is_finish;
  assign res_o       = '{verdict: verdict, crc: crc_final};

endmodule

`default_nettype wire

// File: hw/rtl/slv_out_stage.sv
// ----------------------------------------------------------------------------
// slv_out_stage
// Result register on the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module slv_out_stage
  import slv_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 res_valid_i,
  input  wire result_t              res_i,
  input  wire logic                 out_stall_i,
  output logic                      out_blocked_o,
  output logic                      out_valid_o,
  output logic [VERDICT_W-1:0]      out_verdict_o,
  output logic [CRC_W-1:0]          out_computed_crc_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // full and not taken this cycle
  assign out_blocked_o = valid_q & out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (res_valid_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o        = valid_q;
  assign out_verdict_o      = res_q.verdict;
  assign out_computed_crc_o = res_q.crc;

endmodule

`default_nettype wire
